// ----- sv/cie94_color_difference_core_defines.svh -----
// ---------------------------------------------------------------------------
// CIE94 core assertion macros
// Shared property shorthands for the concurrent checks of the core.
// ---------------------------------------------------------------------------
`ifndef CIE94_COLOR_DIFFERENCE_CORE_DEFINES_SVH
`define CIE94_COLOR_DIFFERENCE_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define C94_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define C94_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/c94_pkg.sv -----
// ---------------------------------------------------------------------------
// CIE94 package
// Field types, register codes and reset values shared by the core files.
// ---------------------------------------------------------------------------
package c94_pkg;

    localparam int WEIGHT_BITS = 16;
    localparam int CFG_IDX_W   = 2;

    typedef logic        [14:0] t_light;
    typedef logic signed [15:0] t_chan;
    typedef logic        [16:0] t_de;
    typedef logic        [WEIGHT_BITS-1:0] t_weight;
    typedef logic        [CFG_IDX_W-1:0]   t_cfg_idx;

    localparam t_cfg_idx REG_CHROMA_WEIGHT = 2'd0;
    localparam t_cfg_idx REG_HUE_WEIGHT    = 2'd1;

    localparam t_weight CHROMA_WEIGHT_RST = 16'd2949;
    localparam t_weight HUE_WEIGHT_RST    = 16'd983;

    localparam t_de DE_MAX = 17'h1FFFF;

endpackage

// ----- sv/c94_in_if.sv -----
// ---------------------------------------------------------------------------
// CIE94 input channel
// Carries one pair of CIELAB colors per item.
// ---------------------------------------------------------------------------
interface c94_in_if;
    import c94_pkg::*;

    logic   valid;
    logic   ready;
    t_light ref_lightness;
    t_chan  ref_green_red;
    t_chan  ref_blue_yellow;
    t_light cmp_lightness;
    t_chan  cmp_green_red;
    t_chan  cmp_blue_yellow;

    modport source (
        output valid, ref_lightness, ref_green_red, ref_blue_yellow,
        output cmp_lightness, cmp_green_red, cmp_blue_yellow,
        input  ready
    );
    modport sink (
        input  valid, ref_lightness, ref_green_red, ref_blue_yellow,
        input  cmp_lightness, cmp_green_red, cmp_blue_yellow,
        output ready
    );
endinterface

// ----- sv/c94_out_if.sv -----
// ---------------------------------------------------------------------------
// CIE94 output channel
// Carries one color difference per item.
// ---------------------------------------------------------------------------
interface c94_out_if;
    import c94_pkg::*;

    logic valid;
    logic ready;
    t_de  delta_e;

    modport source (output valid, delta_e, input ready);
    modport sink   (input valid, delta_e, output ready);
endinterface

// ----- sv/c94_cfg_if.sv -----
// ---------------------------------------------------------------------------
// CIE94 configuration channel
// Register writes: index and data.
// ---------------------------------------------------------------------------
interface c94_cfg_if;
    import c94_pkg::*;

    logic     valid;
    logic     ready;
    t_cfg_idx index;
    t_weight  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/c94_sqrt_cell.sv -----
// ---------------------------------------------------------------------------
// CIE94 square root cell
// One digit of a digit-by-digit integer square root, registered.
// ---------------------------------------------------------------------------
module c94_sqrt_cell #(
    parameter int W = 32,
    parameter int K = 0
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_x,
    input  logic [W-1:0] i_res,
    output logic [W-1:0] o_x,
    output logic [W-1:0] o_res
);
    localparam logic [W-1:0] BIT = {{(W-1){1'b0}}, 1'b1} << (W - 2 - 2 * K);

    logic [W:0]   trial;
    logic [W-1:0] n_x;
    logic [W-1:0] n_res;
    logic [W-1:0] r_x;
    logic [W-1:0] r_res;

    assign trial = {1'b0, i_res} + {1'b0, BIT};

    always_comb begin
        if ({1'b0, i_x} >= trial) begin
            n_x   = i_x - trial[W-1:0];
            n_res = (i_res >> 1) + BIT;
        end else begin
            n_x   = i_x;
            n_res = i_res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x   <= n_x;
            r_res <= n_res;
        end
    end

    assign o_x   = r_x;
    assign o_res = r_res;
endmodule

// ----- sv/c94_div_cell.sv -----
// ---------------------------------------------------------------------------
// CIE94 divider cell
// One quotient bit of a restoring division, registered; the divisor rides along.
// ---------------------------------------------------------------------------
module c94_div_cell #(
    parameter int NW = 41,
    parameter int DW = 33,
    parameter int Q  = 17,
    parameter int K  = 0
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_rem,
    input  logic [DW-1:0] i_div,
    input  logic [Q-1:0]  i_quo,
    output logic [NW-1:0] o_rem,
    output logic [DW-1:0] o_div,
    output logic [Q-1:0]  o_quo
);
    localparam int SH = Q - 1 - K;
    localparam int CW = (NW > DW + Q) ? NW : DW + Q;
    localparam logic [Q-1:0] QBIT = {{(Q-1){1'b0}}, 1'b1} << SH;

    logic [CW-1:0] trial;
    logic [CW-1:0] rem_x;
    logic          ge;
    logic [NW-1:0] r_rem;
    logic [DW-1:0] r_div;
    logic [Q-1:0]  r_quo;

    assign trial = CW'(i_div) << SH;
    assign rem_x = CW'(i_rem);
    assign ge    = rem_x >= trial;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= ge ? NW'(rem_x - trial) : i_rem;
            r_div <= i_div;
            r_quo <= ge ? (i_quo | QBIT) : i_quo;
        end
    end

    assign o_rem = r_rem;
    assign o_div = r_div;
    assign o_quo = r_quo;
endmodule

// ----- sv/c94_delay.sv -----
// ---------------------------------------------------------------------------
// CIE94 delay line
// Holds side data in step with a chain of cells.
// ---------------------------------------------------------------------------
module c94_delay #(
    parameter int W = 8,
    parameter int N = 4
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_d
);
    logic [W-1:0] r_tap [N];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tap[0] <= i_d;
            for (int i = 1; i < N; i++) begin
                r_tap[i] <= r_tap[i-1];
            end
        end
    end

    assign o_d = r_tap[N-1];
endmodule

// ----- sv/cie94_color_difference_core.sv -----
// ---------------------------------------------------------------------------
// CIE94 color difference core
// Throughput: one item per cycle while the output buffer is not full, set by the
// rows of one-digit square root and divider cells that every item walks through,
// one cell per cycle.
// A two-entry output buffer decouples the pipeline from the consumer.
// Reset clears the pipeline valid bits and the buffer and loads default weights.
// ---------------------------------------------------------------------------
`include "cie94_color_difference_core_defines.svh"

module cie94_color_difference_core #(
    parameter int FRAC_BITS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    c94_in_if.sink     i_in,
    c94_out_if.source  o_out,
    c94_cfg_if.sink    i_cfg
);
    import c94_pkg::*;

    localparam int SCALE = FRAC_BITS + WEIGHT_BITS;
    localparam int SW    = ((SCALE > 32) ? SCALE : 32) + 1;
    localparam int QB    = 17;
    localparam int NW    = QB + SCALE;
    localparam int CW_C  = 32;
    localparam int CW_H  = 34;
    localparam int CW_E  = 36;
    localparam int NC    = CW_C / 2;
    localparam int NH    = CW_H / 2;
    localparam int NE    = CW_E / 2;
    localparam int L     = 3 + NC + 3 + NH + QB + 2 + NE;

    // Configuration
    t_weight r_chroma_w;
    t_weight r_hue_w;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chroma_w <= CHROMA_WEIGHT_RST;
            r_hue_w    <= HUE_WEIGHT_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_CHROMA_WEIGHT: r_chroma_w <= i_cfg.data;
                REG_HUE_WEIGHT:    r_hue_w    <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Flow control
    logic         w_en;
    logic [L-1:0] r_vld;
    t_de          r_buf [2];
    logic         r_wptr;
    logic         r_rptr;
    logic [1:0]   r_cnt;
    logic         w_push;
    logic         w_pop;

    assign w_en       = r_cnt != 2'd2;
    assign i_in.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[L-2:0], i_in.valid};
        end
    end

    // Stage 0: input registers
    t_light r_s0_l1, r_s0_l2;
    t_chan  r_s0_a1, r_s0_b1, r_s0_a2, r_s0_b2;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_l1 <= i_in.ref_lightness;
            r_s0_a1 <= i_in.ref_green_red;
            r_s0_b1 <= i_in.ref_blue_yellow;
            r_s0_l2 <= i_in.cmp_lightness;
            r_s0_a2 <= i_in.cmp_green_red;
            r_s0_b2 <= i_in.cmp_blue_yellow;
        end
    end

    // Stage 1: magnitudes and differences
    logic [16:0] w_da_s, w_db_s;
    logic [15:0] w_dl_s;
    logic [15:0] r_s1_am1, r_s1_bm1, r_s1_am2, r_s1_bm2, r_s1_da, r_s1_db;
    logic [14:0] r_s1_dl;

    assign w_da_s = {r_s0_a1[15], r_s0_a1} - {r_s0_a2[15], r_s0_a2};
    assign w_db_s = {r_s0_b1[15], r_s0_b1} - {r_s0_b2[15], r_s0_b2};
    assign w_dl_s = {1'b0, r_s0_l1} - {1'b0, r_s0_l2};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_am1 <= r_s0_a1[15] ? (~r_s0_a1 + 16'd1) : r_s0_a1;
            r_s1_bm1 <= r_s0_b1[15] ? (~r_s0_b1 + 16'd1) : r_s0_b1;
            r_s1_am2 <= r_s0_a2[15] ? (~r_s0_a2 + 16'd1) : r_s0_a2;
            r_s1_bm2 <= r_s0_b2[15] ? (~r_s0_b2 + 16'd1) : r_s0_b2;
            r_s1_da  <= w_da_s[16] ? 16'(~w_da_s + 17'd1) : w_da_s[15:0];
            r_s1_db  <= w_db_s[16] ? 16'(~w_db_s + 17'd1) : w_db_s[15:0];
            r_s1_dl  <= w_dl_s[15] ? 15'(~w_dl_s + 16'd1) : w_dl_s[14:0];
        end
    end

    // Stage 2: squares
    logic [CW_C-1:0] r_s2_sq1, r_s2_sq2;
    logic [32:0]     r_s2_ab2;
    logic [14:0]     r_s2_dl;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_sq1 <= {16'b0, r_s1_am1} * {16'b0, r_s1_am1}
                      + {16'b0, r_s1_bm1} * {16'b0, r_s1_bm1};
            r_s2_sq2 <= {16'b0, r_s1_am2} * {16'b0, r_s1_am2}
                      + {16'b0, r_s1_bm2} * {16'b0, r_s1_bm2};
            r_s2_ab2 <= {17'b0, r_s1_da} * {17'b0, r_s1_da}
                      + {17'b0, r_s1_db} * {17'b0, r_s1_db};
            r_s2_dl  <= r_s1_dl;
        end
    end

    // Chroma of both colors
    logic [CW_C-1:0] w_c1x [NC+1];
    logic [CW_C-1:0] w_c1r [NC+1];
    logic [CW_C-1:0] w_c2x [NC+1];
    logic [CW_C-1:0] w_c2r [NC+1];
    logic [47:0]     w_a_out;

    assign w_c1x[0] = r_s2_sq1;
    assign w_c1r[0] = '0;
    assign w_c2x[0] = r_s2_sq2;
    assign w_c2r[0] = '0;

    for (genvar k = 0; k < NC; k++) begin : g_chroma
        c94_sqrt_cell #(.W(CW_C), .K(k)) u_c1 (
            .i_clk(i_clk), .i_en(w_en), .i_x(w_c1x[k]), .i_res(w_c1r[k]),
            .o_x(w_c1x[k+1]), .o_res(w_c1r[k+1])
        );
        c94_sqrt_cell #(.W(CW_C), .K(k)) u_c2 (
            .i_clk(i_clk), .i_en(w_en), .i_x(w_c2x[k]), .i_res(w_c2r[k]),
            .o_x(w_c2x[k+1]), .o_res(w_c2r[k+1])
        );
    end

    c94_delay #(.W(48), .N(NC)) u_dly_a (
        .i_clk(i_clk), .i_en(w_en), .i_d({r_s2_ab2, r_s2_dl}), .o_d(w_a_out)
    );

    // Stages P1 to P3: chroma difference, weighting divisors, hue radicand
    logic [15:0]   w_c1, w_c2;
    logic [15:0]   r_p1_c1, r_p1_dc;
    logic [32:0]   r_p1_ab2;
    logic [14:0]   r_p1_dl;
    logic [31:0]   w_kc, w_kh;
    logic [15:0]   r_p2_dc;
    logic [31:0]   r_p2_dc2;
    logic [SW-1:0] r_p2_sc, r_p2_sh;
    logic [32:0]   r_p2_ab2;
    logic [14:0]   r_p2_dl;
    logic [32:0]   r_p3_rad;
    logic [15:0]   r_p3_dc;
    logic [SW-1:0] r_p3_sc, r_p3_sh;
    logic [14:0]   r_p3_dl;

    assign w_c1 = w_c1r[NC][15:0];
    assign w_c2 = w_c2r[NC][15:0];
    assign w_kc = {16'b0, r_chroma_w} * {16'b0, r_p1_c1};
    assign w_kh = {16'b0, r_hue_w} * {16'b0, r_p1_c1};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1_c1  <= w_c1;
            r_p1_dc  <= (w_c1 >= w_c2) ? w_c1 - w_c2 : w_c2 - w_c1;
            r_p1_ab2 <= w_a_out[47:15];
            r_p1_dl  <= w_a_out[14:0];

            r_p2_dc  <= r_p1_dc;
            r_p2_dc2 <= {16'b0, r_p1_dc} * {16'b0, r_p1_dc};
            r_p2_sc  <= (SW'(1) << SCALE) + SW'(w_kc);
            r_p2_sh  <= (SW'(1) << SCALE) + SW'(w_kh);
            r_p2_ab2 <= r_p1_ab2;
            r_p2_dl  <= r_p1_dl;

            // A negative hue radicand counts as zero.
            r_p3_rad <= (r_p2_ab2 > {1'b0, r_p2_dc2}) ? r_p2_ab2 - {1'b0, r_p2_dc2} : '0;
            r_p3_dc  <= r_p2_dc;
            r_p3_sc  <= r_p2_sc;
            r_p3_sh  <= r_p2_sh;
            r_p3_dl  <= r_p2_dl;
        end
    end

    // Hue difference
    logic [CW_H-1:0]         w_hx [NH+1];
    logic [CW_H-1:0]         w_hr [NH+1];
    logic [16+2*SW+15-1:0]   w_b_out;

    assign w_hx[0] = {1'b0, r_p3_rad};
    assign w_hr[0] = '0;

    for (genvar k = 0; k < NH; k++) begin : g_hue
        c94_sqrt_cell #(.W(CW_H), .K(k)) u_h (
            .i_clk(i_clk), .i_en(w_en), .i_x(w_hx[k]), .i_res(w_hr[k]),
            .o_x(w_hx[k+1]), .o_res(w_hr[k+1])
        );
    end

    c94_delay #(.W(16 + 2 * SW + 15), .N(NH)) u_dly_b (
        .i_clk(i_clk), .i_en(w_en), .i_d({r_p3_dc, r_p3_sc, r_p3_sh, r_p3_dl}),
        .o_d(w_b_out)
    );

    // Weighted chroma and hue terms
    logic [15:0]   w_b_dc;
    logic [SW-1:0] w_b_sc, w_b_sh;
    logic [14:0]   w_b_dl;
    logic [16:0]   w_dh;
    logic [NW-1:0] w_tc_rem [QB+1];
    logic [SW-1:0] w_tc_div [QB+1];
    logic [QB-1:0] w_tc_quo [QB+1];
    logic [NW-1:0] w_th_rem [QB+1];
    logic [SW-1:0] w_th_div [QB+1];
    logic [QB-1:0] w_th_quo [QB+1];
    logic [14:0]   w_c_dl;

    assign {w_b_dc, w_b_sc, w_b_sh, w_b_dl} = w_b_out;
    assign w_dh = w_hr[NH][16:0];

    assign w_tc_rem[0] = NW'(w_b_dc) << SCALE;
    assign w_tc_div[0] = w_b_sc;
    assign w_tc_quo[0] = '0;
    assign w_th_rem[0] = NW'(w_dh) << SCALE;
    assign w_th_div[0] = w_b_sh;
    assign w_th_quo[0] = '0;

    for (genvar k = 0; k < QB; k++) begin : g_div
        c94_div_cell #(.NW(NW), .DW(SW), .Q(QB), .K(k)) u_tc (
            .i_clk(i_clk), .i_en(w_en),
            .i_rem(w_tc_rem[k]), .i_div(w_tc_div[k]), .i_quo(w_tc_quo[k]),
            .o_rem(w_tc_rem[k+1]), .o_div(w_tc_div[k+1]), .o_quo(w_tc_quo[k+1])
        );
        c94_div_cell #(.NW(NW), .DW(SW), .Q(QB), .K(k)) u_th (
            .i_clk(i_clk), .i_en(w_en),
            .i_rem(w_th_rem[k]), .i_div(w_th_div[k]), .i_quo(w_th_quo[k]),
            .o_rem(w_th_rem[k+1]), .o_div(w_th_div[k+1]), .o_quo(w_th_quo[k+1])
        );
    end

    c94_delay #(.W(15), .N(QB)) u_dly_c (
        .i_clk(i_clk), .i_en(w_en), .i_d(w_b_dl), .o_d(w_c_dl)
    );

    // Squares and sum of the three terms
    logic [33:0]     r_q_tc2, r_q_th2;
    logic [29:0]     r_q_dl2;
    logic [CW_E-1:0] r_u_sum;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_q_tc2 <= {17'b0, w_tc_quo[QB]} * {17'b0, w_tc_quo[QB]};
            r_q_th2 <= {17'b0, w_th_quo[QB]} * {17'b0, w_th_quo[QB]};
            r_q_dl2 <= {15'b0, w_c_dl} * {15'b0, w_c_dl};
            r_u_sum <= CW_E'(r_q_tc2) + CW_E'(r_q_th2) + CW_E'(r_q_dl2);
        end
    end

    // Final root
    logic [CW_E-1:0] w_ex [NE+1];
    logic [CW_E-1:0] w_er [NE+1];
    t_de             w_de;

    assign w_ex[0] = r_u_sum;
    assign w_er[0] = '0;

    for (genvar k = 0; k < NE; k++) begin : g_delta
        c94_sqrt_cell #(.W(CW_E), .K(k)) u_e (
            .i_clk(i_clk), .i_en(w_en), .i_x(w_ex[k]), .i_res(w_er[k]),
            .o_x(w_ex[k+1]), .o_res(w_er[k+1])
        );
    end

    assign w_de = w_er[NE][17] ? DE_MAX : w_er[NE][16:0];

    // Output buffer
    assign w_push        = w_en && r_vld[L-1];
    assign w_pop         = o_out.valid && o_out.ready;
    assign o_out.valid   = r_cnt != 2'd0;
    assign o_out.delta_e = r_buf[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wptr <= ~r_wptr;
            end
            if (w_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wptr] <= w_de;
        end
    end

    `C94_ASSERT_NOW(a_buf_bound, i_clk, i_rst_n, 1'b1, r_cnt <= 2'd2, "output buffer overflow")
    `C94_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, !w_en, $stable(r_vld), "pipeline moved while stalled")
    `C94_ASSERT_NEXT(a_accept_enter, i_clk, i_rst_n, i_in.valid && i_in.ready, r_vld[0], "accepted item lost at entry")
    `C94_ASSERT_NEXT(a_full_stall, i_clk, i_rst_n, r_cnt == 2'd2 && !w_pop, !i_in.ready, "input taken with full buffer")
endmodule

// ----- tb/tb_cie94_color_difference_core.sv -----
// ---------------------------------------------------------------------------
// CIE94 color difference core testbench
// Drives color pairs through the core under random stalls on both sides,
// predicts each delta E in fixed point and compares it with the output item.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_cie94_color_difference_core;
    import c94_pkg::*;

    localparam int FRAC = 8;
    localparam int LIMIT_CYCLES = 400000;

    typedef struct packed {
        t_light ref_l;
        t_chan  ref_a;
        t_chan  ref_b;
        t_light cmp_l;
        t_chan  cmp_a;
        t_chan  cmp_b;
    } t_pair;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    c94_in_if  in_ch();
    c94_out_if out_ch();
    c94_cfg_if cfg_ch();

    cie94_color_difference_core #(.FRAC_BITS(FRAC)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .o_out(out_ch), .i_cfg(cfg_ch)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_pair   pending_pairs[$];
    t_de     expected_de[$];
    t_weight k1_weight = CHROMA_WEIGHT_RST;
    t_weight k2_weight = HUE_WEIGHT_RST;
    int      errors = 0;
    int      cycle_count = 0;
    bit      calm = 1'b0;

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned abs_val(longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    function automatic t_de cie94_delta(t_pair p);
        longint unsigned dl, da, db, c1, c2, dc, ab2, dc2, dh, one, sc, sh, tc, th, r;
        dl = abs_val(longint'(p.ref_l) - longint'(p.cmp_l));
        da = abs_val(longint'(p.ref_a) - longint'(p.cmp_a));
        db = abs_val(longint'(p.ref_b) - longint'(p.cmp_b));
        c1 = int_sqrt(abs_val(p.ref_a) * abs_val(p.ref_a) + abs_val(p.ref_b) * abs_val(p.ref_b));
        c2 = int_sqrt(abs_val(p.cmp_a) * abs_val(p.cmp_a) + abs_val(p.cmp_b) * abs_val(p.cmp_b));
        dc = (c1 >= c2) ? c1 - c2 : c2 - c1;
        ab2 = da * da + db * db;
        dc2 = dc * dc;
        dh = (ab2 > dc2) ? int_sqrt(ab2 - dc2) : 0;
        one = 64'd1 << (FRAC + WEIGHT_BITS);
        sc = one + k1_weight * c1;
        sh = one + k2_weight * c1;
        tc = (dc * one) / sc;
        th = (dh * one) / sh;
        r = int_sqrt(dl * dl + tc * tc + th * th);
        if (r > DE_MAX) r = DE_MAX;
        return t_de'(r);
    endfunction

    function automatic bit idle_now();
        return !calm && ($urandom_range(99) < 28);
    endfunction

    // Driver: the prediction is made when the item is accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                expected_de.push_back(cie94_delta(pending_pairs.pop_front()));
            end
            if ((!in_ch.valid || in_ch.ready)) begin
                if (pending_pairs.size() != 0 && !idle_now()) begin
                    in_ch.valid           <= 1'b1;
                    in_ch.ref_lightness   <= pending_pairs[0].ref_l;
                    in_ch.ref_green_red   <= pending_pairs[0].ref_a;
                    in_ch.ref_blue_yellow <= pending_pairs[0].ref_b;
                    in_ch.cmp_lightness   <= pending_pairs[0].cmp_l;
                    in_ch.cmp_green_red   <= pending_pairs[0].cmp_a;
                    in_ch.cmp_blue_yellow <= pending_pairs[0].cmp_b;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor with a randomly stalling ready.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_de.size() == 0) begin
                    $error("delta_e: unexpected item, actual %0d", out_ch.delta_e);
                    errors++;
                end else begin
                    if (out_ch.delta_e !== expected_de[0]) begin
                        $error("delta_e: expected %0d actual %0d", expected_de[0],
                               out_ch.delta_e);
                        errors++;
                    end
                    void'(expected_de.pop_front());
                end
            end
            out_ch.ready <= !idle_now();
        end
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.ref_lightness = '0;
        in_ch.ref_green_red = '0;
        in_ch.ref_blue_yellow = '0;
        in_ch.cmp_lightness = '0;
        in_ch.cmp_green_red = '0;
        in_ch.cmp_blue_yellow = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_CHROMA_WEIGHT;
        cfg_ch.data = '0;
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES) @(posedge i_clk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic write_reg(t_cfg_idx idx, t_weight val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        if (idx == REG_CHROMA_WEIGHT) k1_weight = val;
        else if (idx == REG_HUE_WEIGHT) k2_weight = val;
    endtask

    task automatic drain();
        while (pending_pairs.size() != 0 || in_ch.valid || expected_de.size() != 0)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    function automatic t_pair make_pair(t_light rl, t_chan ra, t_chan rb,
                                        t_light cl, t_chan ca, t_chan cb);
        t_pair p;
        p = '{rl, ra, rb, cl, ca, cb};
        return p;
    endfunction

    function automatic t_pair random_pair();
        t_pair p;
        p.ref_l = t_light'($urandom);
        p.cmp_l = t_light'($urandom);
        p.ref_a = t_chan'($urandom);
        p.ref_b = t_chan'($urandom);
        p.cmp_a = t_chan'($urandom);
        p.cmp_b = t_chan'($urandom);
        // Most items are plausible colors: L* within 0..100, small a* and b*.
        if ($urandom_range(3) != 0) begin
            p.ref_l = t_light'($urandom_range(25600));
            p.cmp_l = t_light'($urandom_range(25600));
            p.ref_a = t_chan'(int'($urandom_range(65535)) / 2 - 16384);
            p.ref_b = t_chan'(int'($urandom_range(65535)) / 2 - 16384);
            p.cmp_a = p.ref_a + t_chan'(int'($urandom_range(4095)) - 2048);
            p.cmp_b = p.ref_b + t_chan'(int'($urandom_range(4095)) - 2048);
        end
        return p;
    endfunction

    task automatic run_phase(t_weight k1, t_weight k2, int count);
        write_reg(REG_CHROMA_WEIGHT, k1);
        write_reg(REG_HUE_WEIGHT, k2);
        // An out-of-range index must leave both weights alone.
        write_reg(t_cfg_idx'(3), t_weight'($urandom));
        repeat (count) pending_pairs.push_back(random_pair());
        drain();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items under the reset weights, with no idling.
        calm = 1'b1;
        pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0));
        pending_pairs.push_back(make_pair(25600, 0, 0, 0, 0, 0));
        pending_pairs.push_back(make_pair(15'h7FFF, 0, 0, 0, 0, 0));
        pending_pairs.push_back(make_pair(0, 16'sh7FFF, 16'sh7FFF, 15'h7FFF, -16'sh8000, -16'sh8000));
        pending_pairs.push_back(make_pair(15'h7FFF, -16'sh8000, -16'sh8000, 0, 16'sh7FFF, 16'sh7FFF));
        pending_pairs.push_back(make_pair(12800, 5000, 0, 12800, 0, 5000));
        pending_pairs.push_back(make_pair(12800, 5000, 0, 12800, -5000, 0));
        pending_pairs.push_back(make_pair(12800, 3, 4, 12800, 4, 3));
        pending_pairs.push_back(make_pair(12800, 3, 0, 12800, 0, 2));
        pending_pairs.push_back(make_pair(100, -16'sh8000, 0, 200, 0, 16'sh7FFF));
        pending_pairs.push_back(make_pair(0, 16'sh7FFF, -16'sh8000, 0, 16'sh7FFF, -16'sh8000));
        pending_pairs.push_back(make_pair(15'h5555, 16'sh5555, -16'sh5556, 15'h2AAA, -16'sh2AAB, 16'sh2AAA));
        drain();
        // Weights of zero make both divisors exactly one.
        write_reg(REG_CHROMA_WEIGHT, '0);
        write_reg(REG_HUE_WEIGHT, '0);
        pending_pairs.push_back(make_pair(0, 16'sh7FFF, 16'sh7FFF, 15'h7FFF, -16'sh8000, -16'sh8000));
        pending_pairs.push_back(make_pair(12800, 5000, 0, 12800, 0, 5000));
        pending_pairs.push_back(make_pair(12800, 3, 0, 12800, 0, 2));
        drain();
        calm = 1'b0;

        run_phase(CHROMA_WEIGHT_RST, HUE_WEIGHT_RST, 150);
        run_phase(16'hFFFF, 16'hFFFF, 80);
        run_phase('0, '0, 80);
        run_phase(t_weight'($urandom), t_weight'($urandom), 80);
        calm = 1'b1;
        run_phase('0, 16'hFFFF, 60);
        calm = 1'b0;
        run_phase(16'hFFFF, '0, 50);

        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
